FILE: rtl/pfe_pkg.sv
// Shared types and constants of the postfix expression evaluator.
package pfe_pkg;

   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_TIMES = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      ST_OK,
      ST_OVERFLOW,
      ST_UNDERFLOW,
      ST_DIVZERO
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_READ_A,
      S_OPERATE,
      S_START,
      S_ITER,
      S_WRITE,
      S_FETCH,
      S_RESPOND
   } pfe_state_type;

   typedef struct packed {
      logic       load_char;
      logic       push_digit;
      logic       rd_second;
      logic       load_b;
      logic       load_a;
      logic       start_iter;
      logic       step;
      logic       push_result;
      status_type flag;
      logic       load_rsp;
      logic       clear_expr;
   } pfe_cmd_type;

   typedef struct packed {
      logic is_digit;
      logic is_op;
      logic is_arith;
      logic is_div;
      logic last;
      logic full;
      logic few;
      logic b_zero;
      logic iter_last;
      logic out_free;
   } pfe_status_type;

endpackage

FILE: rtl/pfe_if.sv
// Valid/ready channels for characters in and results out.
interface pfe_req_if import pfe_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, char_code, last, input ready);
   modport sink   (input valid, char_code, last, output ready);
endinterface

interface pfe_rsp_if import pfe_pkg::*; #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   status_type                    status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

FILE: rtl/postfix_expression_evaluator_core.sv
// Top level of the postfix expression evaluator.
//
// Characters of a postfix expression enter on req_if (char_code, last) with a
// valid/ready handshake; one result per expression leaves on rsp_if (value,
// status) after the item marked last. Digits push 0..9 onto a value stack of
// STACK_DEPTH entries; + - * / pop two values and push the VALUE_WIDTH-bit
// wrapped result, division truncating toward zero.
// Each character is done before the next is accepted. * and / run on the
// shared shift-add / restoring divide unit, which retires one bit per cycle
// (a divide by zero skips it); every operator fetches its two operands one
// after the other through the single-port stack read.
// After the item marked last the block fetches the top of stack and loads the
// result register; the stack and status then clear for the next expression.
// The result register holds an item until rsp_if.ready; while it is full the
// block keeps taking characters and only stalls on the next last item.
// Synchronous reset empties the stack, clears the status and drops any result.
module postfix_expression_evaluator_core import pfe_pkg::*; #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   pfe_req_if.sink   req_if,
   pfe_rsp_if.source rsp_if
);

   pfe_cmd_type    cmd;
   pfe_status_type status;
   logic           req_ready;

   assign req_if.ready = req_ready;

   pfe_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfe_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_if.char_code),
      .req_last      (req_if.last),
      .cmd           (cmd),
      .status        (status),
      .rsp_if        (rsp_if)
   );

endmodule

FILE: rtl/pfe_datapath.sv
// Value stack, operand registers, shared shift-add / restoring divide unit and result register.
module pfe_datapath import pfe_pkg::*; #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              req_last,
   input  pfe_cmd_type       cmd,
   output pfe_status_type    status,
   pfe_rsp_if.source         rsp_if
);

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(VALUE_WIDTH);
   localparam int W      = VALUE_WIDTH;

   logic [W-1:0]      stack_mem [STACK_DEPTH];
   logic [W-1:0]      rd_data_ff;

   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;
   logic [SP_W-1:0]   sp_ff, sp_in;
   status_type        err_ff, err_in;
   logic [W-1:0]      a_ff, b_ff, x_ff, y_ff, acc_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [W-1:0]      value_ff;
   status_type        status_ff;
   logic              rsp_valid_ff;

   logic [SP_W-1:0]   sp_m1, sp_m2;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [W-1:0]      wr_data, digit, result, prod_sum, mag_a, mag_b, quot;
   logic [W:0]        rem_sh, diff;
   logic              fits, neg_a, neg_b;
   logic              is_digit, is_arith, is_div, is_op;

   // character decode
   always_comb begin
      is_digit = char_ff inside {[CH_ZERO:CH_NINE]};
      is_arith = (char_ff == CH_PLUS) || (char_ff == CH_MINUS);
      is_div   = (char_ff == CH_SLASH);
      is_op    = is_arith || is_div || (char_ff == CH_TIMES);
   end

   assign sp_m1   = sp_ff - SP_W'(1);
   assign sp_m2   = sp_ff - SP_W'(2);
   assign rd_addr = cmd.rd_second ? sp_m2[ADDR_W-1:0] : sp_m1[ADDR_W-1:0];
   assign wr_addr = cmd.push_digit ? sp_ff[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];
   assign digit   = W'(char_ff[3:0]);
   assign wr_data = cmd.push_digit ? digit : result;

   // shared iterative unit
   assign neg_a    = a_ff[W-1];
   assign neg_b    = b_ff[W-1];
   assign mag_a    = neg_a ? (W'(0) - a_ff) : a_ff;
   assign mag_b    = neg_b ? (W'(0) - b_ff) : b_ff;
   assign prod_sum = acc_ff + (y_ff[0] ? x_ff : W'(0));
   assign rem_sh   = {acc_ff, x_ff[W-1]};
   assign diff     = rem_sh - {1'b0, y_ff};
   assign fits     = !diff[W];
   assign quot     = (neg_a ^ neg_b) ? (W'(0) - x_ff) : x_ff;

   always_comb begin
      case (char_ff)
         CH_PLUS:  result = a_ff + b_ff;
         CH_MINUS: result = a_ff - b_ff;
         CH_SLASH: result = (b_ff == W'(0)) ? W'(0) : quot;
         default:  result = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.push_digit || cmd.push_result) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         char_ff <= req_char_code;
         last_ff <= req_last;
      end
      if (cmd.load_b) begin
         b_ff <= rd_data_ff;
      end
      if (cmd.load_a) begin
         a_ff <= rd_data_ff;
      end
      if (cmd.start_iter) begin
         x_ff   <= is_div ? mag_a : a_ff;
         y_ff   <= is_div ? mag_b : b_ff;
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         if (is_div) begin
            acc_ff <= fits ? diff[W-1:0] : rem_sh[W-1:0];
            x_ff   <= {x_ff[W-2:0], fits};
         end else begin
            acc_ff <= prod_sum;
            x_ff   <= {x_ff[W-2:0], 1'b0};
            y_ff   <= {1'b0, y_ff[W-1:1]};
         end
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.load_rsp) begin
         value_ff  <= (sp_ff == '0) ? W'(0) : rd_data_ff;
         status_ff <= err_ff;
      end
   end

   always_comb begin
      sp_in = sp_ff;
      if (cmd.clear_expr) begin
         sp_in = '0;
      end else if (cmd.push_digit) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (cmd.push_result) begin
         sp_in = sp_m1;
      end
   end

   // keep only the first error of an expression
   always_comb begin
      err_in = err_ff;
      if (cmd.clear_expr) begin
         err_in = ST_OK;
      end else if ((cmd.flag != ST_OK) && (err_ff == ST_OK)) begin
         err_in = cmd.flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff  <= sp_in;
         err_ff <= err_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = value_ff;
   assign rsp_if.status = status_ff;

   always_comb begin
      status.is_digit  = is_digit;
      status.is_op     = is_op;
      status.is_arith  = is_arith;
      status.is_div    = is_div;
      status.last      = last_ff;
      status.full      = (sp_ff == SP_W'(STACK_DEPTH));
      status.few       = (sp_ff < SP_W'(2));
      status.b_zero    = (b_ff == W'(0));
      status.iter_last = (cnt_ff == CNT_W'(VALUE_WIDTH - 1));
      status.out_free  = !rsp_valid_ff || rsp_if.ready;
   end

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_pop_needs_two: assert property (@(posedge clock) disable iff (reset)
      cmd.push_result |-> sp_ff >= SP_W'(2))
      else $error("result pushed without two operands popped");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && !cmd.clear_expr) |=> err_ff == $past(err_ff))
      else $error("recorded error changed within an expression");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("result register loaded while holding an untaken item");

endmodule

FILE: rtl/pfe_controller.sv
// Sequencer that steps each character through decode, stack access and arithmetic.
module pfe_controller import pfe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  pfe_status_type status,
   output pfe_cmd_type    cmd
);

   pfe_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.is_op && !status.few) begin
               state_in = S_READ_A;
            end else begin
               state_in = status.last ? S_FETCH : S_IDLE;
            end
         end
         S_READ_A:  state_in = S_OPERATE;
         S_OPERATE: state_in = status.is_arith ? S_WRITE : S_START;
         S_START: begin
            state_in = (status.is_div && status.b_zero) ? S_WRITE : S_ITER;
         end
         S_ITER: begin
            if (status.iter_last) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE:   state_in = status.last ? S_FETCH : S_IDLE;
         S_FETCH:   state_in = S_RESPOND;
         S_RESPOND: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.flag  = ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_char = req_valid;
         end
         S_EXEC: begin
            // drop a digit that finds the stack full; flag an operator with fewer than two values
            if (status.is_digit) begin
               if (status.full) begin
                  cmd.flag = ST_OVERFLOW;
               end else begin
                  cmd.push_digit = 1'b1;
               end
            end else if (status.is_op && status.few) begin
               cmd.flag = ST_UNDERFLOW;
            end
         end
         S_READ_A: begin
            cmd.load_b    = 1'b1;
            cmd.rd_second = 1'b1;
         end
         S_OPERATE: cmd.load_a = 1'b1;
         S_START: begin
            if (status.is_div && status.b_zero) begin
               cmd.flag = ST_DIVZERO;
            end else begin
               cmd.start_iter = 1'b1;
            end
         end
         S_ITER:  cmd.step = 1'b1;
         S_WRITE: cmd.push_result = 1'b1;
         S_FETCH: begin
         end
         S_RESPOND: begin
            cmd.load_rsp   = status.out_free;
            cmd.clear_expr = status.out_free;
         end
         default: begin
         end
      endcase
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_EXEC)
      else $error("accepted item not decoded in the next cycle");

   a_iter_exits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER && status.iter_last) |=> state_ff == S_WRITE)
      else $error("iteration did not end on its last step");

   a_respond_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESPOND && !status.out_free) |=> state_ff == S_RESPOND)
      else $error("result dropped while the output register was busy");

endmodule

FILE: test/postfix_expression_evaluator_core_tb.sv
// Self-checking testbench of the postfix expression evaluator core.
module postfix_expression_evaluator_core_tb import pfe_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 60;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      status_type             status;
   } answer_type;

   typedef struct packed {
      logic [CHAR_W-1:0]      char_code;
      logic                   last;
      logic                   typed;
      logic [VALUE_WIDTH-1:0] value;
      status_type             status;
   } stim_row_type;

   logic clock;
   logic reset;

   pfe_req_if req_if ();
   pfe_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp_if ();

   postfix_expression_evaluator_core #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Evaluator state as seen from outside.
   logic [VALUE_WIDTH-1:0] calc_stack [STACK_DEPTH];
   int unsigned            calc_depth;
   status_type             calc_status;

   answer_type   answers_due [$];
   stim_row_type directed_rows [$];
   logic [CHAR_W-1:0] expr_chars [$];

   int mismatch_count = 0;
   int chars_sent = 0;
   int answers_checked = 0;
   int error_answers = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] want,
                                  input logic [VALUE_WIDTH-1:0] got);
      if (mismatch_count < 40)
         $display("%0t mismatch: %s expected %0h got %0h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   function automatic void note_error(input status_type code);
      if (calc_status == ST_OK)
         calc_status = code;
   endfunction

   function automatic void push_operand(input logic [VALUE_WIDTH-1:0] v);
      if (calc_depth >= STACK_DEPTH) begin
         note_error(ST_OVERFLOW);
      end else begin
         calc_stack[calc_depth] = v;
         calc_depth++;
      end
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] quotient_toward_zero(
         input logic [VALUE_WIDTH-1:0] a, input logic [VALUE_WIDTH-1:0] b);
      logic [VALUE_WIDTH-1:0] mag_a, mag_b, q;
      mag_a = a[VALUE_WIDTH-1] ? -a : a;
      mag_b = b[VALUE_WIDTH-1] ? -b : b;
      q = mag_a / mag_b;
      return (a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1]) ? -q : q;
   endfunction

   function automatic void evaluate_char(input logic [CHAR_W-1:0] c, input logic lst,
                                         output bit gives, output answer_type ans);
      logic [VALUE_WIDTH-1:0] a, b, r;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         push_operand(VALUE_WIDTH'(c - CH_ZERO));
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_TIMES || c == CH_SLASH) begin
         if (calc_depth < 2) begin
            note_error(ST_UNDERFLOW);
         end else begin
            b = calc_stack[calc_depth-1];
            a = calc_stack[calc_depth-2];
            calc_depth -= 2;
            if (c == CH_PLUS) begin
               r = a + b;
            end else if (c == CH_MINUS) begin
               r = a - b;
            end else if (c == CH_TIMES) begin
               r = a * b;
            end else if (b == '0) begin
               note_error(ST_DIVZERO);
               r = '0;
            end else begin
               r = quotient_toward_zero(a, b);
            end
            push_operand(r);
         end
      end
      gives = lst;
      ans.value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
      ans.status = calc_status;
      if (lst) begin
         calc_depth = 0;
         calc_status = ST_OK;
      end
   endfunction

   // Present one item, wait for it to be taken, then predict its answer.
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic lst, input logic typed,
                            input logic [VALUE_WIDTH-1:0] tv, input status_type ts);
      bit gives;
      answer_type ans;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.char_code <= c;
      req_if.last <= lst;
      do @(posedge clock); while (!req_if.ready);
      chars_sent++;
      evaluate_char(c, lst, gives, ans);
      if (gives) begin
         if (typed) begin
            ans.value = tv;
            ans.status = ts;
         end
         answers_due.push_back(ans);
      end
   endtask

   task automatic add_row(input logic [CHAR_W-1:0] c, input logic lst, input logic typed,
                          input logic [VALUE_WIDTH-1:0] v, input status_type s);
      directed_rows.push_back('{c, lst, typed, v, s});
   endtask

   function automatic logic [CHAR_W-1:0] random_digit();
      if ($urandom_range(3) == 0)
         return CHAR_W'(CH_ZERO + $urandom_range(1));
      return CHAR_W'(CH_ZERO + $urandom_range(9));
   endfunction

   function automatic logic [CHAR_W-1:0] random_operator();
      case ($urandom_range(3))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_TIMES;
         default: return CH_SLASH;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] random_filler();
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom_range(255));
      if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
          c == CH_TIMES || c == CH_SLASH)
         return CH_SPACE;
      return c;
   endfunction

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare every answer taken from the block with the oldest one due.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (answers_due.size() == 0) begin
            report_mismatch("answer with none due", '0, rsp_if.value);
         end else begin
            want = answers_due.pop_front();
            if (rsp_if.value !== want.value)
               report_mismatch("value", want.value, rsp_if.value);
            if (rsp_if.status !== want.status)
               report_mismatch("status", VALUE_WIDTH'(want.status), VALUE_WIDTH'(rsp_if.status));
         end
         answers_checked++;
         if (rsp_if.status != ST_OK)
            error_answers++;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout with %0d answers outstanding", answers_due.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int counted;
      int kind;
      int depth;
      int n;
      int phase;
      stim_row_type row;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.char_code = '0;
      req_if.last = 1'b0;
      rsp_if.ready = 1'b0;
      calc_depth = 0;
      calc_status = ST_OK;
      foreach (calc_stack[i]) calc_stack[i] = '0;

      // Single digit right after reset, empty stack, lone operator.
      add_row("7", 1'b1, 1'b1, 32'd7, ST_OK);
      add_row(CH_SPACE, 1'b1, 1'b1, '0, ST_OK);
      add_row(CH_PLUS, 1'b1, 1'b1, '0, ST_UNDERFLOW);
      // Division by zero pushes zero.
      add_row("8", 1'b0, 1'b0, '0, ST_OK);
      add_row("0", 1'b0, 1'b0, '0, ST_OK);
      add_row(CH_SLASH, 1'b1, 1'b1, '0, ST_DIVZERO);
      // Operand order for subtract and divide.
      add_row("3", 1'b0, 1'b0, '0, ST_OK);
      add_row("4", 1'b0, 1'b0, '0, ST_OK);
      add_row(CH_MINUS, 1'b1, 1'b0, '0, ST_OK);
      add_row("9", 1'b0, 1'b0, '0, ST_OK);
      add_row("2", 1'b0, 1'b0, '0, ST_OK);
      add_row(CH_SLASH, 1'b1, 1'b0, '0, ST_OK);
      // Ignored characters at both code extremes.
      add_row(8'h00, 1'b0, 1'b0, '0, ST_OK);
      add_row("6", 1'b0, 1'b0, '0, ST_OK);
      add_row(8'hFF, 1'b0, 1'b0, '0, ST_OK);
      add_row("1", 1'b0, 1'b0, '0, ST_OK);
      add_row(CH_TIMES, 1'b1, 1'b0, '0, ST_OK);
      // First error sticks over a later divide by zero.
      add_row(CH_MINUS, 1'b0, 1'b0, '0, ST_OK);
      add_row("5", 1'b0, 1'b0, '0, ST_OK);
      add_row("0", 1'b0, 1'b0, '0, ST_OK);
      add_row(CH_SLASH, 1'b1, 1'b1, '0, ST_UNDERFLOW);
      // Underflow leaves the stack as it was.
      add_row("9", 1'b0, 1'b0, '0, ST_OK);
      add_row("9", 1'b0, 1'b0, '0, ST_OK);
      add_row(CH_TIMES, 1'b0, 1'b0, '0, ST_OK);
      add_row(CH_MINUS, 1'b1, 1'b1, 32'd81, ST_UNDERFLOW);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_char(row.char_code, row.last, row.typed, row.value, row.status);
      end

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         phase = counted * 4 / RANDOM_ITEMS;
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
         endcase

         expr_chars.delete();
         kind = $urandom_range(99);
         if (kind < 75) begin
            // Well-formed expression; from kind 60 up one stray operator goes in at a random place.
            depth = 0;
            n = $urandom_range(1, 28);
            for (int i = 0; i < n; i++) begin
               if (depth < 2 || (depth < 15 && $urandom_range(1) == 0)) begin
                  expr_chars.push_back(random_digit());
                  depth++;
               end else begin
                  expr_chars.push_back(random_operator());
                  depth--;
               end
               if ($urandom_range(5) == 0)
                  expr_chars.push_back(random_filler());
            end
            while (depth > 1 && $urandom_range(3) != 0) begin
               expr_chars.push_back(random_operator());
               depth--;
            end
            if (kind >= 60)
               expr_chars.insert($urandom_range(expr_chars.size()), random_operator());
         end else if (kind < 85) begin
            n = $urandom_range(1, 12);
            repeat (n) expr_chars.push_back(CHAR_W'($urandom_range(255)));
         end else if (kind < 93) begin
            // Fill the stack to near, at or past full, then apply up to four operators.
            n = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 4);
            repeat (n) expr_chars.push_back(random_digit());
            n = $urandom_range(0, 4);
            repeat (n) expr_chars.push_back(random_operator());
         end else begin
            // Build 8^10 * 2, which wraps to the most negative value.
            expr_chars.push_back("8");
            repeat (9) begin
               expr_chars.push_back("8");
               expr_chars.push_back(CH_TIMES);
            end
            expr_chars.push_back("2");
            expr_chars.push_back(CH_TIMES);
            case ($urandom_range(3))
               0: begin
                  expr_chars.push_back("0");
                  expr_chars.push_back("1");
                  expr_chars.push_back(CH_MINUS);
                  expr_chars.push_back(CH_SLASH);
               end
               1: begin
                  expr_chars.push_back("0");
                  expr_chars.push_back("1");
                  expr_chars.push_back(CH_MINUS);
                  expr_chars.push_back(CH_TIMES);
               end
               2: begin
                  expr_chars.push_back("1");
                  expr_chars.push_back(CH_MINUS);
               end
               default: ;
            endcase
         end

         foreach (expr_chars[i]) begin
            send_char(expr_chars[i], i == expr_chars.size() - 1, 1'b0, '0, ST_OK);
            counted++;
         end
      end
      req_if.valid <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d characters; checked %0d expression answers, %0d with an error status",
               chars_sent, answers_checked, error_answers);
      $display("Covered stack overflow, underflow, divide by zero and value wraparound, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
